FILE: hw/rtl/sle_pkg.sv
// Shared types and codes of the sequential list engine.
`default_nettype none

package sle_pkg;

  localparam int unsigned OpW  = 3;
  localparam int unsigned PosW = 5;
  localparam int unsigned ValW = 32;
  localparam int unsigned StsW = 2;

  typedef enum logic [OpW-1:0] {
    OP_GET     = 3'd0,
    OP_LOCATE  = 3'd1,
    OP_INSERT  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_ORDERED = 3'd4
  } op_e;

  typedef enum logic [StsW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [ValW-1:0]     read_value;
    logic [PosW-1:0]     found_position;
    logic [PosW-1:0]     count_after;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sle_ram.sv
// Entry store: one write port and one registered read port.
`default_nettype none

module sle_ram
  import sle_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire logic [ValW-1:0] wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output logic      [ValW-1:0] rdata_o
);

  logic [ValW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sle_cmp.sv
// Shared compare unit: equality and signed less-than on one stored word.
`default_nettype none

module sle_cmp
  import sle_pkg::*;
(
  input  wire logic [ValW-1:0] a_i,
  input  wire logic [ValW-1:0] b_i,
  output logic                 eq_o,
  output logic                 lt_o
);

  assign eq_o = (a_i == b_i);
  assign lt_o = ($signed(a_i) < $signed(b_i));

endmodule

`default_nettype wire

FILE: hw/rtl/sle_seq.sv
// Request sequencer: scans and shifts the entry store one word per cycle.
`default_nettype none

module sle_seq
  import sle_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // request side
  input  wire logic            start_i,
  input  wire logic [OpW-1:0]  op_i,
  input  wire logic [PosW-1:0] pos_i,
  input  wire logic [ValW-1:0] val_i,
  output logic                 ready_o,
  // result side
  input  wire logic            out_free_i,
  output logic                 done_o,
  output result_t              res_o,
  // entry store
  output logic                 we_o,
  output logic      [AW-1:0]   waddr_o,
  output logic      [ValW-1:0] wdata_o,
  output logic      [AW-1:0]   raddr_o,
  input  wire logic [ValW-1:0] rdata_i,
  // compare unit
  output logic      [ValW-1:0] cmp_a_o,
  output logic      [ValW-1:0] cmp_b_o,
  input  wire logic            cmp_eq_i,
  input  wire logic            cmp_lt_i
);

  localparam int unsigned XW = CW + PosW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DECODE = 10'b00_0000_0010,
    S_GET    = 10'b00_0000_0100,
    S_SCAN   = 10'b00_0000_1000,
    S_DEL    = 10'b00_0001_0000,
    S_SHDN   = 10'b00_0010_0000,
    S_OPEN   = 10'b00_0100_0000,
    S_SHUP   = 10'b00_1000_0000,
    S_PUT    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   j_q, j_d;
  op_e             op_q, op_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [ValW-1:0] val_q, val_d;
  status_e         sts_q, sts_d;
  logic [ValW-1:0] rd_q, rd_d;
  logic [PosW-1:0] found_q, found_d;

  logic [XW-1:0]   pos_x, cnt_x, found_x;
  logic [CW-1:0]   pos_idx;
  logic [CW-1:0]   raddr_w;
  logic            bad_rd, bad_ins, full, empty, last;

  assign pos_x   = {{CW{1'b0}}, pos_q};
  assign cnt_x   = {{PosW{1'b0}}, count_q};
  assign found_x = {{PosW{1'b0}}, idx_q} + XW'(1);
  assign pos_idx = CW'(pos_x - XW'(1));
  assign bad_rd  = (pos_q == '0) || (pos_x > cnt_x);
  assign bad_ins = (pos_q == '0) || (pos_x > cnt_x + XW'(1));
  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);
  assign last    = (idx_q + CW'(1) == count_q);

  assign cmp_a_o = rdata_i;
  assign cmp_b_o = val_q;
  assign raddr_o = raddr_w[AW-1:0];

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    j_d     = j_q;
    op_d    = op_q;
    pos_d   = pos_q;
    val_d   = val_q;
    sts_d   = sts_q;
    rd_d    = rd_q;
    found_d = found_q;
    raddr_w = '0;
    we_o    = 1'b0;
    waddr_o = '0;
    wdata_o = rdata_i;
    ready_o = 1'b0;
    done_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          op_d    = op_e'(op_i);
          pos_d   = pos_i;
          val_d   = val_i;
          sts_d   = ST_OK;
          rd_d    = '0;
          found_d = '0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_GET: begin
            if (bad_rd) begin
              sts_d   = ST_RANGE;
              state_d = S_DONE;
            end else begin
              raddr_w = pos_idx;
              state_d = S_GET;
            end
          end
          OP_LOCATE: begin
            if (empty) begin
              state_d = S_DONE;
            end else begin
              idx_d   = '0;
              state_d = S_SCAN;
            end
          end
          OP_INSERT: begin
            if (bad_ins) begin
              sts_d   = ST_RANGE;
              state_d = S_DONE;
            end else if (full) begin
              sts_d   = ST_FULL;
              state_d = S_DONE;
            end else begin
              idx_d   = pos_idx;
              state_d = S_OPEN;
            end
          end
          OP_DELETE: begin
            if (bad_rd) begin
              sts_d   = ST_RANGE;
              state_d = S_DONE;
            end else begin
              raddr_w = pos_idx;
              idx_d   = pos_idx;
              state_d = S_DEL;
            end
          end
          OP_ORDERED: begin
            if (full) begin
              sts_d   = ST_FULL;
              state_d = S_DONE;
            end else begin
              idx_d   = '0;
              state_d = empty ? S_OPEN : S_SCAN;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_GET: begin
        rd_d    = rdata_i;
        state_d = S_DONE;
      end
      S_SCAN: begin
        // word at idx_q is on the read port; fetch the next one meanwhile
        raddr_w = idx_q + CW'(1);
        if (op_q == OP_LOCATE) begin
          if (cmp_eq_i) begin
            found_d = found_x[PosW-1:0];
            state_d = S_DONE;
          end else if (last) begin
            state_d = S_DONE;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end else begin
          if (!cmp_lt_i) begin
            state_d = S_OPEN;
          end else if (last) begin
            idx_d   = count_q;
            state_d = S_OPEN;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end
      S_OPEN: begin
        if (idx_q == count_q) begin
          state_d = S_PUT;
        end else begin
          raddr_w = count_q - CW'(1);
          j_d     = count_q;
          state_d = S_SHUP;
        end
      end
      S_SHUP: begin
        we_o    = 1'b1;
        waddr_o = j_q[AW-1:0];
        raddr_w = j_q - CW'(2);
        if (j_q - CW'(1) == idx_q) begin
          state_d = S_PUT;
        end else begin
          j_d = j_q - CW'(1);
        end
      end
      S_PUT: begin
        we_o    = 1'b1;
        waddr_o = idx_q[AW-1:0];
        wdata_o = val_q;
        count_d = count_q + CW'(1);
        state_d = S_DONE;
      end
      S_DEL: begin
        rd_d = rdata_i;
        if (last) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          raddr_w = idx_q + CW'(1);
          j_d     = idx_q;
          state_d = S_SHDN;
        end
      end
      S_SHDN: begin
        we_o    = 1'b1;
        waddr_o = j_q[AW-1:0];
        raddr_w = j_q + CW'(2);
        if (j_q + CW'(2) == count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_DONE: begin
        done_o = 1'b1;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.status         = sts_q;
  assign res_o.read_value     = rd_q;
  assign res_o.found_position = found_q;
  assign res_o.count_after    = cnt_x[PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    j_q     <= j_d;
    op_q    <= op_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    sts_q   <= sts_d;
    rd_q    <= rd_d;
    found_q <= found_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sequential_list_engine.sv
// Top level of the sequential list engine: stream ports, sequencer, store and result register.
`default_nettype none

// Array list of up to DEPTH signed 32-bit words with a length count. Each input word is one
// request (get, locate, insert at position, delete at position, ordered insert) and produces
// exactly one result word. The block takes one request at a time: s_axis_tready_o is high
// only while the sequencer is idle. Entries live in a single-port-write, single-port-read
// memory with registered read data, so every scan or shift moves one entry per cycle. Get
// reads the entry at the position; locate compares entries from the first until a match or
// the last entry; insert at position moves the entries from that position on up by one;
// delete at position moves the entries after it down by one; ordered insert compares up to
// the insert point and moves the entries from there on up by one. Rejected requests (bad
// position, full list) finish after the decode cycle and leave the list untouched. The result
// sits in an output register; the next request is accepted while it still waits, and a later
// result holds in the sequencer until that register frees up. The entry store is not cleared
// at reset; only entries below the count are ever used. count_after and found_position
// carry the low five bits of their values.

module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // position[4:0], value[36:5], zero pad
  input  wire logic [2:0]  s_axis_tuser_i,  // operation[2:0]
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [47:0] m_axis_tdata_o,  // read_value[31:0], found_position[36:32],
                                            // count_after[41:37], zero pad
  output logic      [1:0]  m_axis_tuser_o   // status[1:0]
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic            start, seq_ready, seq_done, out_free;
  result_t         seq_res;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [ValW-1:0] wdata, rdata;
  logic [ValW-1:0] cmp_a, cmp_b;
  logic            cmp_eq, cmp_lt;

  logic            m_valid_q, m_valid_d;
  result_t         m_res_q;

  // a request word is taken when the sequencer is idle
  assign s_axis_tready_o = seq_ready;
  assign start           = s_axis_tvalid_i & seq_ready;

  // result register frees up when empty or when its word is taken this cycle
  assign out_free = !m_valid_q || m_axis_tready_i;

  sle_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .op_i       (s_axis_tuser_i),
    .pos_i      (s_axis_tdata_i[4:0]),
    .val_i      (s_axis_tdata_i[36:5]),
    .ready_o    (seq_ready),
    .out_free_i (out_free),
    .done_o     (seq_done),
    .res_o      (seq_res),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .cmp_a_o    (cmp_a),
    .cmp_b_o    (cmp_b),
    .cmp_eq_i   (cmp_eq),
    .cmp_lt_i   (cmp_lt)
  );

  sle_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sle_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .eq_o (cmp_eq),
    .lt_o (cmp_lt)
  );

  // load a finished result, drop the held word once it is taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (seq_done && out_free) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done && out_free) begin
      m_res_q <= seq_res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_res_q.status;
  assign m_axis_tdata_o  = {6'd0, m_res_q.count_after, m_res_q.found_position,
                            m_res_q.read_value};

endmodule

`default_nettype wire
